@@ sv/bfrl_pkg.sv @@
`timescale 1ns / 1ps
package bfrl_pkg;

    localparam int unsigned PROGRAM_DEPTH_DEF = 1024;
    localparam int unsigned TAPE_DEPTH_DEF    = 1024;
    localparam int unsigned NEST_DEPTH_DEF    = 64;

    // Command kinds held in the program store.
    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_INC   = 4'd1;
    localparam logic [3:0] KIND_DEC   = 4'd2;
    localparam logic [3:0] KIND_RIGHT = 4'd3;
    localparam logic [3:0] KIND_LEFT  = 4'd4;
    localparam logic [3:0] KIND_OPEN  = 4'd5;
    localparam logic [3:0] KIND_CLOSE = 4'd6;
    localparam logic [3:0] KIND_OUT   = 4'd7;
    localparam logic [3:0] KIND_IN    = 4'd8;

    // Result status codes.
    localparam logic [2:0] ST_LOADED     = 3'd0;
    localparam logic [2:0] ST_OUTPUT     = 3'd1;
    localparam logic [2:0] ST_NEED_INPUT = 3'd2;
    localparam logic [2:0] ST_HALTED     = 3'd3;
    localparam logic [2:0] ST_STEP_LIMIT = 3'd4;
    localparam logic [2:0] ST_UNBALANCED = 3'd5;
    localparam logic [2:0] ST_FULL       = 3'd6;
    localparam logic [2:0] ST_TAPE       = 3'd7;

    // Machine modes.
    localparam logic [2:0] MODE_LOADING = 3'd0;
    localparam logic [2:0] MODE_READY   = 3'd1;
    localparam logic [2:0] MODE_WAIT    = 3'd2;
    localparam logic [2:0] MODE_HALTED  = 3'd3;

    localparam int unsigned OPCODE_LOAD = 0;

    // Map a program character to its command kind.
    function automatic logic [3:0] kind_of(input logic [7:0] ch);
        logic [3:0] k;
        case (ch)
            8'h2B:   k = KIND_INC;
            8'h2D:   k = KIND_DEC;
            8'h3E:   k = KIND_RIGHT;
            8'h3C:   k = KIND_LEFT;
            8'h5B:   k = KIND_OPEN;
            8'h5D:   k = KIND_CLOSE;
            8'h2E:   k = KIND_OUT;
            8'h2C:   k = KIND_IN;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ sv/brainfuck_run_length_machine.sv @@
`timescale 1ns / 1ps
// Run-length Brainfuck machine. Each slave transfer is one item: a load item
// (opcode 0) appends a program character, a run item (opcode 1) executes until
// '.', ',', end of program, step budget or an error; every item answers with
// exactly one master transfer carrying a status and a byte. A load item passes
// through a program store read for merging, the merge or append write, and the
// answer; a ']' also writes itself in a state of its own and patches the
// target of its partner with the answer. A run item has a setup state, then
// for each executed command a fetch state, in which the program store read and
// the tape read are registered, and an execute state with the update unit. An
// item that is ignored or answered with a sticky failure is answered in the
// cycle after its transfer. No new item is taken until the answer has been
// transferred. After reset, a clearing pass zeroes the tape, one cell a cycle,
// before the first item is taken. Configuration (step_budget) is to be written
// by the user only while the block is idle; the block itself does not enforce
// this.
module brainfuck_run_length_machine
    import bfrl_pkg::*;
#(
    parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
    parameter int unsigned TAPE_DEPTH    = TAPE_DEPTH_DEF,
    parameter int unsigned NEST_DEPTH    = NEST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [7:0] code_char, [15:8] input_byte
    input  logic [15:0] s_axis_tdata,
    // tuser: opcode
    input  logic        s_axis_tuser,
    // tlast: last_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    // tuser: [2:0] status
    output logic [2:0]  m_axis_tuser
);

    localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);
    localparam int unsigned PLW = $clog2(PROGRAM_DEPTH + 1);
    localparam int unsigned TAW = $clog2(TAPE_DEPTH);
    localparam int unsigned TLW = $clog2(TAPE_DEPTH + 1);
    localparam int unsigned NAW = $clog2(NEST_DEPTH);
    localparam int unsigned NLW = $clog2(NEST_DEPTH + 1);
    // Argument holds a jump target, a count to 255 or a move to TAPE_DEPTH.
    localparam int unsigned AW0 = (PAW > TLW) ? PAW : TLW;
    localparam int unsigned AW  = (AW0 > 8) ? AW0 : 8;
    localparam int unsigned WW  = ((PLW > TLW) ? PLW : TLW) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LD_READ, S_LD_MERGE, S_LD_CLOSE, S_RUN_START,
        S_FETCH, S_EXEC, S_RESP
    } t_state;

    typedef struct packed {
        logic [3:0]    kind;
        logic [AW-1:0] arg;
    } t_cmd;

    t_state r_state;
    t_cmd   r_prog [PROGRAM_DEPTH];
    logic [PAW-1:0] r_stack [NEST_DEPTH];
    logic [7:0]     r_tape [TAPE_DEPTH];

    t_cmd           r_cmd;          // registered program store read
    logic [NAW-1:0] r_stack_q;      // registered stack read address
    logic [7:0]     r_cell;         // registered tape read
    logic [PLW-1:0] r_plen;
    logic [NLW-1:0] r_depth;
    logic [TAW-1:0] r_dp;
    logic [PLW-1:0] r_pc;
    logic [2:0]     r_mode;
    logic [2:0]     r_fail;         // nonzero once failed
    logic [31:0]    r_budget;
    logic [32:0]    r_steps;
    logic [TAW-1:0] r_clr;
    logic [7:0]     r_char;
    logic           r_last;
    logic [7:0]     r_inb;
    logic [2:0]     r_status;
    logic [7:0]     r_obyte;
    logic           r_ovalid;
    logic [PAW-1:0] r_pop;
    logic           r_fix_we;       // open bracket target still to be patched
    logic [PAW-1:0] r_fix_at;       // index of that open bracket

    logic [3:0] w_kind;
    assign w_kind = kind_of(r_char);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tuser  = r_status;

    // Update unit: an 8-bit adder/subtractor for cells and an adder/subtractor with bound compare for pointer moves.
    logic [7:0]    w_cell_sum;
    logic [WW-1:0] w_mv_a, w_mv_b;
    logic          w_mv_bad;
    logic [WW-1:0] w_mv_res;
    always_comb begin
        w_cell_sum = (r_cmd.kind == KIND_DEC) ? r_cell - r_cmd.arg[7:0]
                                              : r_cell + r_cmd.arg[7:0];
        w_mv_a = WW'(r_dp);
        w_mv_b = WW'(r_cmd.arg);
        if (r_cmd.kind == KIND_RIGHT) begin
            w_mv_res = w_mv_a + w_mv_b;
            w_mv_bad = w_mv_res >= WW'(TAPE_DEPTH);
        end else begin
            w_mv_res = w_mv_a - w_mv_b;
            w_mv_bad = w_mv_b > w_mv_a;
        end
    end

    // Memories: program store, bracket stack, tape.
    logic           w_pwe;
    logic [PAW-1:0] w_pwa;
    t_cmd           w_pwd;
    logic [PAW-1:0] w_pra;
    logic           w_twe;
    logic [TAW-1:0] w_twa;
    logic [7:0]     w_twd;
    logic           w_swe;

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_prog[w_pwa] <= w_pwd;
        end
        r_cmd <= r_prog[w_pra];
        if (w_twe) begin
            r_tape[w_twa] <= w_twd;
        end
        r_cell <= r_tape[r_dp];
        if (w_swe) begin
            r_stack[r_depth[NAW-1:0]] <= r_plen[PAW-1:0];
        end
        r_pop <= r_stack[r_stack_q];
    end

    logic [PLW-1:0] w_pm1;
    assign w_pm1 = r_plen - 1'b1;

    // Memory control driven from state.
    always_comb begin
        w_pwe = 1'b0;
        w_pwa = r_plen[PAW-1:0];
        w_pwd = r_cmd;
        w_pra = r_pc[PAW-1:0];
        w_twe = 1'b0;
        w_twa = r_dp;
        w_twd = w_cell_sum;
        w_swe = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_twe = 1'b1;
                w_twa = r_clr;
                w_twd = 8'd0;
            end
            S_LD_READ: begin
                w_pra = w_pm1[PAW-1:0];
            end
            S_LD_MERGE: begin
                if (w_kind != KIND_NONE) begin
                    if (w_kind <= KIND_LEFT && r_plen != '0 && r_cmd.kind == w_kind) begin
                        w_pwe = 1'b1;
                        w_pwa = w_pm1[PAW-1:0];
                        w_pwd.kind = w_kind;
                        if (w_kind <= KIND_DEC) begin
                            w_pwd.arg = AW'(r_cmd.arg[7:0] + 8'd1);
                        end else if (r_cmd.arg < AW'(TAPE_DEPTH)) begin
                            w_pwd.arg = r_cmd.arg + 1'b1;
                        end else begin
                            w_pwd.arg = r_cmd.arg;
                        end
                    end else if (r_plen < PLW'(PROGRAM_DEPTH) && w_kind != KIND_CLOSE
                                 && !(w_kind == KIND_OPEN && r_depth >= NLW'(NEST_DEPTH))) begin
                        w_pwe = 1'b1;
                        w_pwd.kind = w_kind;
                        w_pwd.arg = (w_kind <= KIND_LEFT) ? AW'(1) : '0;
                        w_swe = (w_kind == KIND_OPEN);
                    end
                end
            end
            S_LD_CLOSE: begin
                // Write the close, then patch its partner on the next cycle.
                w_pwe = 1'b1;
                w_pwd.kind = KIND_CLOSE;
                w_pwd.arg = AW'(r_pop);
            end
            S_RUN_START: begin
                w_twe = (r_mode == MODE_WAIT);
                w_twd = r_inb;
            end
            S_EXEC: begin
                w_twe = (r_cmd.kind == KIND_INC || r_cmd.kind == KIND_DEC);
            end
            S_RESP: begin
                // Patch the open bracket's target after a close was stored.
                w_pwe = r_fix_we;
                w_pwa = r_fix_at;
                w_pwd.kind = KIND_OPEN;
                w_pwd.arg = AW'(w_pm1);
            end
            default: ;
        endcase
    end

    logic [32:0] w_limit;
    assign w_limit = (r_budget == '0) ? 33'h1_0000_0000 : {1'b0, r_budget};

    // Sequencer: state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_plen   <= '0;
            r_depth  <= '0;
            r_dp     <= '0;
            r_pc     <= '0;
            r_mode   <= MODE_LOADING;
            r_fail   <= '0;
            r_budget <= '0;
            r_ovalid <= 1'b0;
            r_status <= ST_LOADED;
            r_obyte  <= '0;
            r_fix_we <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == TAW'(TAPE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_char   <= s_axis_tdata[7:0];
                        r_inb    <= s_axis_tdata[15:8];
                        r_last   <= s_axis_tlast;
                        r_status <= ST_LOADED;
                        r_obyte  <= '0;
                        if (r_fail != '0) begin
                            r_status <= r_fail;
                            r_ovalid <= 1'b1;
                        end else if (s_axis_tuser == 1'(OPCODE_LOAD)) begin
                            if (r_mode == MODE_LOADING) begin
                                r_state <= S_LD_READ;
                            end else begin
                                r_ovalid <= 1'b1;
                            end
                        end else if (r_mode == MODE_LOADING) begin
                            r_ovalid <= 1'b1;
                        end else if (r_mode == MODE_HALTED) begin
                            r_status <= ST_HALTED;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_steps <= '0;
                            r_state <= S_RUN_START;
                        end
                    end
                end
                S_LD_READ: begin
                    r_stack_q <= NAW'(r_depth - 1'b1);
                    r_state   <= S_LD_MERGE;
                end
                S_LD_MERGE: begin
                    r_state <= S_RESP;
                    if (w_kind != KIND_NONE && !w_pwe) begin
                        if (w_kind <= KIND_LEFT && r_plen != '0 && r_cmd.kind == w_kind) begin
                            r_state <= S_RESP;
                        end else if (r_plen >= PLW'(PROGRAM_DEPTH)) begin
                            r_fail <= ST_FULL;
                        end else if (w_kind == KIND_OPEN) begin
                            r_fail <= ST_UNBALANCED;
                        end else if (r_depth == '0) begin
                            r_fail <= ST_UNBALANCED;
                        end else begin
                            r_depth <= r_depth - 1'b1;
                            r_state <= S_LD_CLOSE;
                        end
                    end else if (w_pwe && w_pwa == r_plen[PAW-1:0] && !(w_kind <= KIND_LEFT
                                 && r_plen != '0 && r_cmd.kind == w_kind)) begin
                        r_plen <= r_plen + 1'b1;
                        if (w_kind == KIND_OPEN) begin
                            r_depth <= r_depth + 1'b1;
                        end
                    end
                end
                S_LD_CLOSE: begin
                    r_plen   <= r_plen + 1'b1;
                    r_fix_we <= 1'b1;
                    r_fix_at <= r_pop;
                    r_state  <= S_RESP;
                end
                S_RUN_START: begin
                    if (r_mode == MODE_WAIT) begin
                        r_pc   <= r_pc + 1'b1;
                        r_mode <= MODE_READY;
                    end
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    // Program read of r_pc and tape read of r_dp are issued now, used in S_EXEC.
                    if (r_pc >= r_plen) begin
                        r_mode   <= MODE_HALTED;
                        r_status <= ST_HALTED;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_steps >= w_limit) begin
                        r_status <= ST_STEP_LIMIT;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_FETCH;
                    r_pc    <= r_pc + 1'b1;
                    case (r_cmd.kind)
                        KIND_RIGHT, KIND_LEFT: begin
                            if (w_mv_bad) begin
                                r_fail   <= ST_TAPE;
                                r_pc     <= r_pc;
                                r_status <= ST_TAPE;
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_dp <= TAW'(w_mv_res);
                            end
                        end
                        KIND_OPEN: begin
                            if (r_cell == 8'd0) begin
                                r_pc <= PLW'(r_cmd.arg) + 1'b1;
                            end
                        end
                        KIND_CLOSE: begin
                            if (r_cell != 8'd0) begin
                                r_pc <= PLW'(r_cmd.arg) + 1'b1;
                            end
                        end
                        KIND_OUT: begin
                            r_status <= ST_OUTPUT;
                            r_obyte  <= r_cell;
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        KIND_IN: begin
                            r_pc     <= r_pc;
                            r_mode   <= MODE_WAIT;
                            r_status <= ST_NEED_INPUT;
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        default: ;
                    endcase
                end
                S_RESP: begin
                    // End of a load item: failure code or balance check.
                    r_fix_we <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    if (r_fail != '0) begin
                        r_status <= r_fail;
                    end else if (r_last) begin
                        if (r_depth != '0) begin
                            r_fail   <= ST_UNBALANCED;
                            r_status <= ST_UNBALANCED;
                        end else begin
                            r_mode <= MODE_READY;
                            r_pc   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
